@@ hw/rtl/first_fit_region_allocator_assert.svh @@
// ----------------------------------------------------------------------------
// first_fit_region_allocator_assert
// assertion macros for the first fit region allocator
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_REGION_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_REGION_ALLOCATOR_ASSERT_SVH

// assert that an implication holds at every clock edge outside reset
`define FFRA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assert that a signal keeps its value in the cycle after a condition
`define FFRA_ASSERT_STABLE(label, clk, rst_n, cond, sig, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) else $error(msg);

`endif

@@ hw/rtl/ffra_pkg.sv @@
// ----------------------------------------------------------------------------
// ffra_pkg
// types and constants shared by the first fit region allocator modules
// ----------------------------------------------------------------------------
package ffra_pkg;

  localparam int unsigned HeapBytesDefault   = 4096;
  localparam int unsigned RegionSlotsDefault = 64;

  localparam int unsigned AddrW = 12;
  localparam int unsigned SizeW = 13;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_SIZE  = 2'd2,
    CMD_INFO  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_SIZE  = 3'd1,
    ST_NO_SPACE  = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_NO_SLOT   = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    FSM_IDLE,
    FSM_START,
    FSM_READ,
    FSM_EVAL,
    FSM_SPLIT,
    FSM_SPLIT2,
    FSM_BUMP,
    FSM_BUMP2,
    FSM_DONE
  } fsm_e;

  // controller -> datapath commands
  typedef struct packed {
    logic load;      // capture request
    logic start;     // set walk pointer to chain head
    logic rd;        // issue descriptor read at walk pointer
    logic eval;      // look at read data
    logic advance;   // step to next descriptor
    logic split_a;   // write remainder descriptor
    logic split_b;   // rewrite fitted descriptor
    logic bump_a;    // write new tail descriptor
    logic bump_b;    // relink old tail
    logic finish;    // build result
  } ctl_t;

  // datapath -> controller status
  typedef struct packed {
    logic cmd_alloc;
    logic cmd_info;
    logic bad_size;
    logic walk_end;  // walk pointer null or step limit reached
    logic hit;       // current descriptor matches
    logic need_split;
    logic slot_full;
    logic room;
  } sts_t;

endpackage

@@ hw/rtl/ffra_ctrl.sv @@
// ----------------------------------------------------------------------------
// ffra_ctrl
// sequencer for one request: chain walk, then split or bump writes
// ----------------------------------------------------------------------------
module ffra_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  ffra_pkg::sts_t sts_i,
  output ffra_pkg::ctl_t ctl_o
);
  import ffra_pkg::*;

  fsm_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    ctl_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      FSM_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.load = 1'b1;
          state_d    = FSM_START;
        end
      end
      FSM_START: begin
        ctl_o.start = 1'b1;
        if (sts_i.cmd_alloc && sts_i.bad_size) begin
          ctl_o.finish = 1'b1;
          state_d      = FSM_DONE;
        end else begin
          state_d = FSM_READ;
        end
      end
      FSM_READ: begin
        if (sts_i.walk_end) begin
          if (sts_i.cmd_alloc) begin
            state_d = FSM_BUMP;
          end else begin
            ctl_o.finish = 1'b1;
            state_d      = FSM_DONE;
          end
        end else begin
          ctl_o.rd = 1'b1;
          state_d  = FSM_EVAL;
        end
      end
      FSM_EVAL: begin
        ctl_o.eval = 1'b1;
        if (sts_i.hit && !sts_i.cmd_info) begin
          if (sts_i.cmd_alloc && sts_i.need_split) begin
            if (sts_i.slot_full) begin
              ctl_o.finish = 1'b1;
              state_d      = FSM_DONE;
            end else begin
              state_d = FSM_SPLIT;
            end
          end else begin
            ctl_o.finish = 1'b1;
            state_d      = FSM_DONE;
          end
        end else begin
          ctl_o.advance = 1'b1;
          state_d       = FSM_READ;
        end
      end
      FSM_SPLIT: begin
        ctl_o.split_a = 1'b1;
        state_d       = FSM_SPLIT2;
      end
      FSM_SPLIT2: begin
        ctl_o.split_b = 1'b1;
        ctl_o.finish  = 1'b1;
        state_d       = FSM_DONE;
      end
      FSM_BUMP: begin
        if (sts_i.room && !sts_i.slot_full) begin
          ctl_o.bump_a = 1'b1;
          state_d      = FSM_BUMP2;
        end else begin
          ctl_o.finish = 1'b1;
          state_d      = FSM_DONE;
        end
      end
      FSM_BUMP2: begin
        ctl_o.bump_b = 1'b1;
        ctl_o.finish = 1'b1;
        state_d      = FSM_DONE;
      end
      FSM_DONE: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = FSM_IDLE;
        end
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/ffra_dpath.sv @@
// ----------------------------------------------------------------------------
// ffra_dpath
// descriptor memory, chain registers, totals and result register
// ----------------------------------------------------------------------------
module ffra_dpath #(
  parameter int unsigned HEAP_BYTES   = ffra_pkg::HeapBytesDefault,
  parameter int unsigned REGION_SLOTS = ffra_pkg::RegionSlotsDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [1:0]                 command_i,
  input  logic [ffra_pkg::SizeW-1:0] request_size_i,
  input  logic [ffra_pkg::AddrW-1:0] region_address_i,
  input  ffra_pkg::ctl_t             ctl_i,
  output ffra_pkg::sts_t             sts_o,
  output logic [2:0]                 result_status_o,
  output logic [ffra_pkg::AddrW-1:0] granted_address_o,
  output logic [ffra_pkg::SizeW-1:0] region_bytes_o,
  output logic [ffra_pkg::SizeW-1:0] used_bytes_o,
  output logic [ffra_pkg::SizeW-1:0] free_chunk_bytes_o,
  output logic [ffra_pkg::SizeW-1:0] tail_free_bytes_o
);
  import ffra_pkg::*;

  localparam int unsigned SlotW = $clog2(REGION_SLOTS + 1);
  localparam int unsigned IdxW  = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
  localparam int unsigned TopW  = $clog2(HEAP_BYTES + 1);
  localparam int unsigned SumW  = TopW + 1;
  localparam int unsigned DescW = AddrW + SizeW + 1 + SlotW;
  localparam logic [SlotW-1:0] NilSlot = SlotW'(REGION_SLOTS);
  localparam logic [TopW-1:0] HeapMax = TopW'(HEAP_BYTES);

  // descriptor memory: {link, in_use, length, start}
  logic [DescW-1:0] mem_q [REGION_SLOTS];
  logic [DescW-1:0] rd_q;
  logic             we;
  logic [IdxW-1:0]  wa;
  logic [DescW-1:0] wd;

  logic [1:0]       cmd_q;
  logic [SizeW-1:0] size_q;
  logic [AddrW-1:0] addr_q;

  logic [SlotW-1:0] head_q, tail_q, taken_q, walk_q, tailslot_q;
  logic [SlotW:0]   steps_q;
  logic [TopW-1:0]  top_q;
  logic [SumW-1:0]  used_q, chunk_q;
  logic             hit_q;

  logic [AddrW-1:0] d_start;
  logic [SizeW-1:0] d_len;
  logic             d_use;
  logic [SlotW-1:0] d_link, nxt;
  logic [SizeW-1:0] rest;

  logic [2:0]       st_q;
  logic [AddrW-1:0] ga_q;
  logic [SizeW-1:0] rb_q;

  assign d_start = rd_q[AddrW-1:0];
  assign d_len   = rd_q[AddrW +: SizeW];
  assign d_use   = rd_q[AddrW+SizeW];
  assign d_link  = rd_q[AddrW+SizeW+1 +: SlotW];
  assign nxt     = (d_link < taken_q) ? d_link : NilSlot;
  assign rest    = d_len - size_q;

  logic hit;
  always_comb begin
    unique case (cmd_e'(cmd_q))
      CMD_ALLOC: hit = !d_use && (d_len >= size_q);
      CMD_FREE,
      CMD_SIZE:  hit = (d_start == addr_q);
      default:   hit = 1'b0;
    endcase
  end

  logic [TopW+SizeW-1:0] bump_end;
  assign bump_end = (TopW+SizeW)'(top_q) + (TopW+SizeW)'(size_q);

  assign sts_o.cmd_alloc  = (cmd_q == CMD_ALLOC);
  assign sts_o.cmd_info   = (cmd_q == CMD_INFO);
  assign sts_o.bad_size   = (size_q == '0);
  assign sts_o.walk_end   = (walk_q == NilSlot) || (steps_q >= (SlotW+1)'(REGION_SLOTS));
  assign sts_o.hit        = hit;
  assign sts_o.need_split = (rest != '0);
  assign sts_o.slot_full  = (taken_q >= NilSlot);
  assign sts_o.room       = (bump_end <= (TopW+SizeW)'(HEAP_BYTES));

  // memory write port
  always_comb begin
    we = 1'b0;
    wa = walk_q[IdxW-1:0];
    wd = rd_q;
    if (ctl_i.split_a) begin
      we = 1'b1;
      wa = taken_q[IdxW-1:0];
      wd = {d_link, 1'b0, rest, AddrW'(d_start + AddrW'(size_q))};
    end else if (ctl_i.split_b) begin
      we = 1'b1;
      wd = {tailslot_q, 1'b1, size_q, d_start};
    end else if (ctl_i.eval && hit && (cmd_q == CMD_ALLOC) && (rest == '0)) begin
      we = 1'b1;
      wd = {d_link, 1'b1, d_len, d_start};
    end else if (ctl_i.eval && hit && (cmd_q == CMD_FREE)) begin
      we = 1'b1;
      wd = {d_link, 1'b0, d_len, d_start};
    end else if (ctl_i.bump_a) begin
      we = 1'b1;
      wa = taken_q[IdxW-1:0];
      wd = {NilSlot, 1'b1, size_q, AddrW'(top_q)};
    end else if (ctl_i.bump_b) begin
      // old tail points at the new descriptor, only when the chain was linked
      we = hit_q;
      wa = tailslot_q[IdxW-1:0];
      wd = {tail_q, rd_q[AddrW+SizeW:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    if (ctl_i.rd) begin
      rd_q <= mem_q[walk_q[IdxW-1:0]];
    end else if (ctl_i.bump_a) begin
      // read old tail for the relink, keeping its other fields
      rd_q <= mem_q[tail_q[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q  <= command_i;
      size_q <= request_size_i;
      addr_q <= region_address_i;
    end
  end

  logic linked;
  assign linked = !((head_q >= taken_q) || (tail_q >= taken_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= NilSlot;
      tail_q     <= NilSlot;
      taken_q    <= '0;
      top_q      <= '0;
      walk_q     <= NilSlot;
      steps_q    <= '0;
      used_q     <= '0;
      chunk_q    <= '0;
      hit_q      <= 1'b0;
      tailslot_q <= NilSlot;
      st_q       <= ST_OK;
      ga_q       <= '0;
      rb_q       <= '0;
    end else begin
      if (ctl_i.start) begin
        walk_q  <= (head_q < taken_q) ? head_q : NilSlot;
        steps_q <= '0;
        used_q  <= '0;
        chunk_q <= '0;
        hit_q   <= 1'b0;
      end
      if (ctl_i.eval) begin
        if (cmd_q == CMD_INFO) begin
          if (d_use) used_q <= used_q + SumW'(d_len);
          else       chunk_q <= chunk_q + SumW'(d_len);
        end
        if (hit && cmd_q != CMD_INFO) hit_q <= 1'b1;
      end
      if (ctl_i.advance) begin
        walk_q  <= nxt;
        steps_q <= steps_q + 1'b1;
      end
      if (ctl_i.split_a) begin
        tailslot_q <= taken_q;
        taken_q    <= taken_q + 1'b1;
        if (tail_q == walk_q) tail_q <= taken_q;
      end
      if (ctl_i.bump_a) begin
        taken_q    <= taken_q + 1'b1;
        top_q      <= TopW'(bump_end);
        if (!linked) head_q <= taken_q;
        tailslot_q <= tail_q;
        tail_q     <= taken_q;
        hit_q      <= linked;   // relink needed in the next cycle
      end
      if (ctl_i.finish) begin
        ga_q <= '0;
        rb_q <= '0;
        st_q <= ST_OK;
        unique case (cmd_e'(cmd_q))
          CMD_ALLOC: begin
            if (size_q == '0) begin
              st_q <= ST_BAD_SIZE;
            end else if (ctl_i.split_b) begin
              ga_q <= d_start;
            end else if (ctl_i.bump_b) begin
              ga_q <= AddrW'(top_q - TopW'(size_q));
            end else if (ctl_i.eval) begin
              if (rest != '0) st_q <= ST_NO_SLOT;
              else            ga_q <= d_start;
            end else if (!sts_o.room) begin
              st_q <= ST_NO_SPACE;
            end else begin
              st_q <= ST_NO_SLOT;
            end
          end
          CMD_FREE: begin
            if (!(ctl_i.eval && hit)) st_q <= ST_NOT_FOUND;
          end
          CMD_SIZE: begin
            if (ctl_i.eval && hit) rb_q <= d_len;
            else                   st_q <= ST_NOT_FOUND;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    result_status_o    = st_q;
    granted_address_o  = ga_q;
    region_bytes_o     = rb_q;
    used_bytes_o       = '0;
    free_chunk_bytes_o = '0;
    tail_free_bytes_o  = '0;
    if (cmd_q == CMD_INFO) begin
      used_bytes_o       = used_q[SizeW-1:0];
      free_chunk_bytes_o = chunk_q[SizeW-1:0];
      tail_free_bytes_o  = (top_q <= HeapMax) ? SizeW'(HeapMax - top_q) : '0;
    end
  end

endmodule

@@ hw/rtl/first_fit_region_allocator.sv @@
// ----------------------------------------------------------------------------
// first_fit_region_allocator
// first fit allocator over an address-ordered chain of region descriptors
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one request per transfer: command, request_size and
//   region_address packed in s_axis_tdata_i. m_axis returns one result per
//   request with status, granted address, region size and usage totals.
//   one request is in flight at a time; s_axis_tready_o is high only when
//   the sequencer is idle.
//   each descriptor visited costs a registered read and an evaluate step;
//   the walk visits up to REGION_SLOTS descriptors, and a split or a
//   bump adds descriptor writes after the walk.
//   the next request is taken only after the result is transferred and
//   the sequencer is back in idle.
//   reset empties the chain and the heap top; descriptor memory needs no
//   clearing since the chain only reaches written slots.
//   when the receiver stalls the result stays in its register and no new
//   request is taken until it is transferred.
module first_fit_region_allocator #(
  parameter int unsigned HEAP_BYTES   = ffra_pkg::HeapBytesDefault,
  parameter int unsigned REGION_SLOTS = ffra_pkg::RegionSlotsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // command[1:0], request_size[14:2], region_address[26:15], zero fill
  input  logic [31:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // result_status[2:0], granted_address[14:3], region_bytes[27:15],
  // used_bytes[40:28], free_chunk_bytes[53:41], tail_free_bytes[66:54], zero fill
  output logic [71:0] m_axis_tdata_o
);
  import ffra_pkg::*;

  ctl_t ctl;
  sts_t sts;

  logic [2:0]       status;
  logic [AddrW-1:0] granted;
  logic [SizeW-1:0] rbytes, used, chunks, tailb;

  ffra_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  ffra_dpath #(
    .HEAP_BYTES   (HEAP_BYTES),
    .REGION_SLOTS (REGION_SLOTS)
  ) u_dpath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .command_i          (s_axis_tdata_i[1:0]),
    .request_size_i     (s_axis_tdata_i[14:2]),
    .region_address_i   (s_axis_tdata_i[26:15]),
    .ctl_i              (ctl),
    .sts_o              (sts),
    .result_status_o    (status),
    .granted_address_o  (granted),
    .region_bytes_o     (rbytes),
    .used_bytes_o       (used),
    .free_chunk_bytes_o (chunks),
    .tail_free_bytes_o  (tailb)
  );

  // result fields packed from the low bit up
  assign m_axis_tdata_o = {5'd0, tailb, chunks, used, rbytes, granted, status};

endmodule

@@ hw/rtl/ffra_checker.sv @@
// ----------------------------------------------------------------------------
// ffra_checker
// port level checks of the allocator handshakes and result codes
// ----------------------------------------------------------------------------
`include "first_fit_region_allocator_assert.svh"

module ffra_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [71:0] m_axis_tdata_o
);

  // no new request while a result is pending
  `FFRA_ASSERT(a_no_overlap, clk_i, rst_ni, m_axis_tvalid_o |-> !s_axis_tready_o, "ready during result")
  // stalled result holds
  `FFRA_ASSERT_STABLE(a_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tdata_o, "held")
  // status is a defined code
  `FFRA_ASSERT(a_status, clk_i, rst_ni, m_axis_tvalid_o |-> (m_axis_tdata_o[2:0] <= 3'd4), "bad status")
  // accepted request leaves idle
  `FFRA_ASSERT(a_busy, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o, "still ready")

endmodule

bind first_fit_region_allocator ffra_checker u_ffra_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
